[hw/rtl/stin_pkg.sv]
// stin_pkg: shared types and codes for the sorted key table
// no dependencies; imported by every module of the block

package stin_pkg;

    // request codes
    localparam logic REQ_FIND   = 1'b0;
    localparam logic REQ_INSERT = 1'b1;

    // status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMPARE,
        ST_SEARCH,
        ST_COMMIT
    } t_state;

    // control broadcast to every cell of the chain
    typedef struct packed {
        logic capture;   // latch the compare flag
        logic shift;     // take new key or neighbour key
        logic sign_cmp;  // two's complement order
    } t_cell_ctrl;

endpackage

[hw/rtl/sorted_table_insert.sv]
// sorted_table_insert: ascending key table with upper-bound find and ordered insert
// depends on stin_pkg, stin_cell and stin_search

// One request is handled at a time. A request is taken while the block is idle,
// every cell of the chain then compares its key with the request key in the
// compare state, a bit-serial binary search over the compare flags finds the
// upper bound, and the commit state shifts the chain and loads the result
// register. The next request is taken only once the commit state is left, and
// that state waits while the downstream side stalls a result still held. A new
// request can be taken while the previous result is still waiting. Equal keys go
// after the ones already held. An insert into a full table is refused with status
// set and leaves the table unchanged. Keys are ordered unsigned or as two's
// complement according to the compare_signed register, which the user must write
// through the configuration channel only while no request is in flight; the block
// itself does not enforce this. The upper bound is the length of the leading run
// of entries not greater than the key, so a table left out of order by a change
// of compare_signed is still handled as one flat array. Table contents need no
// clearing after reset; of the table state only the entry count is reset.

module sorted_table_insert import stin_pkg::*; #(
    parameter int CAPACITY  = 256,
    parameter int KEY_WIDTH = 32,
    localparam int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_req_type,
    input  logic [KEY_WIDTH-1:0] i_key,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [CNT_W-1:0]     o_position,
    output logic                 o_status,
    output logic [CNT_W-1:0]     o_entry_count,
    // configuration channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic                 i_cfg_data
);

    localparam logic [KEY_WIDTH-1:0] SignBit = KEY_WIDTH'(1'b1) << (KEY_WIDTH - 1);

    // sequencer
    t_state r_state;
    t_state n_state;

    // request held for the duration of the transaction
    logic                 r_req_type;
    logic [KEY_WIDTH-1:0] r_new_key;
    logic [KEY_WIDTH-1:0] r_ord_key;

    // table state and configuration
    logic [CNT_W-1:0]     r_count;
    logic                 r_cmp_signed;

    // result register
    logic                 r_out_valid;
    logic [CNT_W-1:0]     r_position;
    logic                 r_status;
    logic [CNT_W-1:0]     r_entry_count;

    // control
    logic                 in_accept;
    logic                 out_accept;
    logic                 commit_fire;
    logic                 full;
    logic                 do_insert;
    logic                 search_start;
    t_cell_ctrl           cell_ctrl;

    // chain wiring
    logic [KEY_WIDTH-1:0] w_key [CAPACITY];
    logic [CAPACITY-1:0]  w_le;
    logic                 search_busy;
    logic                 search_last;
    logic [CNT_W-1:0]     search_pos;

    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_accept = r_out_valid && !i_out_stall;
    assign full       = (r_count == CNT_W'(CAPACITY));
    assign do_insert  = (r_req_type == REQ_INSERT) && !full;

    // config register is always writable; caller keeps the block idle
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_signed <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cmp_signed <= i_cfg_data;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_COMPARE;
                end
            end
            ST_COMPARE: n_state = ST_SEARCH;
            ST_SEARCH: begin
                if (search_last) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                // hold until the result register is free or being emptied
                if (!r_out_valid || !i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state-decoded outputs
    always_comb begin
        o_in_stall         = 1'b1;
        search_start       = 1'b0;
        commit_fire        = 1'b0;
        cell_ctrl.capture  = 1'b0;
        cell_ctrl.shift    = 1'b0;
        cell_ctrl.sign_cmp = r_cmp_signed;
        unique case (r_state)
            ST_IDLE: o_in_stall = 1'b0;
            ST_COMPARE: begin
                cell_ctrl.capture = 1'b1;
                search_start      = 1'b1;
            end
            ST_SEARCH: ;
            ST_COMMIT: begin
                commit_fire     = !r_out_valid || !i_out_stall;
                cell_ctrl.shift = commit_fire && do_insert;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // capture the request; ordered key flips the sign bit for signed compare
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_req_type <= i_req_type;
            r_new_key  <= i_key;
            r_ord_key  <= i_key ^ (r_cmp_signed ? SignBit : '0);
        end
    end

    // entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (commit_fire && do_insert) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    // result register, parts the chain from the downstream stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit_fire) begin
            r_out_valid <= 1'b1;
        end else if (out_accept) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit_fire) begin
            r_position    <= search_pos;
            r_status      <= ((r_req_type == REQ_INSERT) && full) ? STATUS_FULL : STATUS_OK;
            r_entry_count <= do_insert ? (r_count + CNT_W'(1)) : r_count;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_position    = r_position;
    assign o_status      = r_status;
    assign o_entry_count = r_entry_count;

    // chain of cells: each takes its left neighbour's key when it lies above the
    // insert point, or the new key when it is the insert point
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [KEY_WIDTH-1:0] prev_key;

        if (g == 0) begin : g_head
            assign prev_key = r_new_key;
        end else begin : g_body
            assign prev_key = w_key[g-1];
        end

        stin_cell #(
            .KEY_WIDTH (KEY_WIDTH),
            .CNT_W     (CNT_W),
            .INDEX     (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (cell_ctrl),
            .i_count    (r_count),
            .i_pos      (search_pos),
            .i_ord_key  (r_ord_key),
            .i_new_key  (r_new_key),
            .i_prev_key (prev_key),
            .o_key      (w_key[g]),
            .o_le       (w_le[g])
        );
    end

    // upper bound is the length of the leading run of not-greater flags
    stin_search #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (search_start),
        .i_le    (w_le),
        .o_busy  (search_busy),
        .o_last  (search_last),
        .o_pos   (search_pos)
    );

`ifndef SYNTHESIS
    // count never runs past the capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // a refused insert is only reported with a full table
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status == STATUS_FULL)) |-> (r_entry_count == CNT_W'(CAPACITY)))
        else $error("full status without a full table");

    // reported position never lies beyond the entries held
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_position <= r_entry_count))
        else $error("position beyond entry count");

    // search unit is idle whenever a new transaction may be taken
    a_idle_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !search_busy)
        else $error("search busy while idle");

    // a committed insert raises the count by exactly one
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit_fire && do_insert) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not raise the count");
`endif

endmodule

[hw/rtl/stin_cell.sv]
// stin_cell: one slot of the sorted key chain, holds a key and its compare flag
// depends on stin_pkg

module stin_cell import stin_pkg::*; #(
    parameter int KEY_WIDTH = 32,
    parameter int CNT_W     = 9,
    parameter int INDEX     = 0
) (
    input  logic                 i_clk,
    input  t_cell_ctrl           i_ctrl,
    input  logic [CNT_W-1:0]     i_count,
    input  logic [CNT_W-1:0]     i_pos,
    input  logic [KEY_WIDTH-1:0] i_ord_key,
    input  logic [KEY_WIDTH-1:0] i_new_key,
    input  logic [KEY_WIDTH-1:0] i_prev_key,
    output logic [KEY_WIDTH-1:0] o_key,
    output logic                 o_le
);

    localparam logic [KEY_WIDTH-1:0] SignBit = KEY_WIDTH'(1'b1) << (KEY_WIDTH - 1);

    logic [KEY_WIDTH-1:0] r_key;
    logic                 r_le;
    logic                 occupied;
    logic [KEY_WIDTH-1:0] ord_own;
    logic                 n_le;
    logic                 below_pos;
    logic                 at_pos;

    assign occupied  = CNT_W'(INDEX) < i_count;
    assign ord_own   = r_key ^ (i_ctrl.sign_cmp ? SignBit : '0);
    assign n_le      = occupied && (ord_own <= i_ord_key);
    assign below_pos = CNT_W'(INDEX) < i_pos;
    assign at_pos    = CNT_W'(INDEX) == i_pos;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_le <= n_le;
        end
        // slots below the insert point keep their key
        if (i_ctrl.shift) begin
            if (at_pos) begin
                r_key <= i_new_key;
            end else if (!below_pos) begin
                r_key <= i_prev_key;
            end
        end
    end

    assign o_key = r_key;
    assign o_le  = r_le;

endmodule

[hw/rtl/stin_search.sv]
// stin_search: bit-serial binary search for the length of the run of set flags
// depends on stin_pkg; reads the compare flags of the cell chain

module stin_search import stin_pkg::*; #(
    parameter int CAPACITY = 256,
    parameter int CNT_W    = 9
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [CAPACITY-1:0] i_le,
    output logic                o_busy,
    output logic                o_last,
    output logic [CNT_W-1:0]    o_pos
);

    localparam int BIT_W = $clog2(CNT_W);

    logic                r_busy;
    logic [BIT_W-1:0]    r_bit;
    logic [CNT_W-1:0]    r_pos;
    logic [CNT_W-1:0]    cand;
    logic [CAPACITY-1:0] below;
    logic                hole;
    logic [CNT_W-1:0]    n_pos;

    // a candidate length is taken when no flag below it is clear, so the leading
    // run is found one bit a cycle even when later flags are set again
    always_comb begin
        cand = r_pos | (CNT_W'(1) << r_bit);
        for (int g = 0; g < CAPACITY; g++) begin
            below[g] = (CNT_W'(g) < cand);
        end
        hole  = |(below & ~i_le);
        n_pos = r_pos;
        if ((cand <= CNT_W'(CAPACITY)) && !hole) begin
            n_pos = cand;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && (r_bit == '0)) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_pos <= '0;
            r_bit <= BIT_W'(CNT_W - 1);
        end else if (r_busy) begin
            r_pos <= n_pos;
            r_bit <= r_bit - BIT_W'(1);
        end
    end

    assign o_busy = r_busy;
    assign o_last = r_busy && (r_bit == '0);
    assign o_pos  = r_pos;

endmodule

[dv/stin_table_scoreboard.sv]
// stin_tb_pkg: scoreboard class for the sorted key table testbench
// keeps its own copy of the table and order register; imports stin_pkg
`timescale 1ns / 1ps

package stin_tb_pkg;
    import stin_pkg::*;

    localparam int          TABLE_DEPTH = 256;
    localparam int          COUNT_W     = 9;
    localparam logic [31:0] SIGN_BIT    = 32'h8000_0000;

    typedef struct packed {
        logic [COUNT_W-1:0] position;
        logic               status;
        logic [COUNT_W-1:0] entry_count;
    } t_table_answer;

    class table_scoreboard;
        logic [31:0]   held_keys[$];
        logic          signed_order;
        t_table_answer awaited[$];
        int unsigned   failures;
        int unsigned   finds;
        int unsigned   inserts;
        int unsigned   refused;
        int unsigned   ties;
        int unsigned   checked;

        function new();
            signed_order = 1'b0;
            failures     = 0;
            finds        = 0;
            inserts      = 0;
            refused      = 0;
            ties         = 0;
            checked      = 0;
        endfunction

        function void set_order(logic sgn);
            signed_order = sgn;
        endfunction

        // flipping the sign bit turns two's complement order into unsigned order
        function logic [31:0] rank(logic [31:0] k);
            return signed_order ? (k ^ SIGN_BIT) : k;
        endfunction

        // first held entry above k, scanning up from the bottom
        function int unsigned upper_bound(logic [31:0] k);
            int unsigned pos;
            pos = 0;
            for (int i = 0; i < held_keys.size(); i++) begin
                if (rank(held_keys[i]) > rank(k)) break;
                pos = i + 1;
            end
            return pos;
        endfunction

        function void note_request(logic req, logic [31:0] k);
            t_table_answer ans;
            int unsigned   pos;
            pos          = upper_bound(k);
            ans.position = COUNT_W'(pos);
            ans.status   = STATUS_OK;
            if (pos != 0 && held_keys[pos-1] == k) ties++;
            if (req == REQ_INSERT) begin
                inserts++;
                if (held_keys.size() >= TABLE_DEPTH) begin
                    ans.status = STATUS_FULL;
                    refused++;
                end else begin
                    held_keys.insert(pos, k);
                end
            end else begin
                finds++;
            end
            ans.entry_count = COUNT_W'(held_keys.size());
            awaited.push_back(ans);
        endfunction

        function void check_result(logic [COUNT_W-1:0] pos, logic st,
                                   logic [COUNT_W-1:0] cnt);
            t_table_answer ans;
            if (awaited.size() == 0) begin
                $error("result transaction with none outstanding: position %0d status %0d entry_count %0d",
                       pos, st, cnt);
                failures++;
            end else begin
                ans = awaited.pop_front();
                checked++;
                if (pos !== ans.position) begin
                    $error("position: expected %0d, actual %0d", ans.position, pos);
                    failures++;
                end
                if (st !== ans.status) begin
                    $error("status: expected %0d, actual %0d", ans.status, st);
                    failures++;
                end
                if (cnt !== ans.entry_count) begin
                    $error("entry_count: expected %0d, actual %0d", ans.entry_count, cnt);
                    failures++;
                end
            end
        endfunction

        function int unsigned waiting();
            return awaited.size();
        endfunction
    endclass

endpackage

[dv/tb_sorted_table_insert.sv]
// tb_sorted_table_insert: self-checking bench for the sorted key table
// depends on stin_pkg, stin_tb_pkg and the sorted_table_insert rtl
`timescale 1ns / 1ps

module tb_sorted_table_insert;
    import stin_pkg::*;
    import stin_tb_pkg::*;

    // cycles with no transaction on any channel before the run is abandoned
    localparam int QUIET_LIMIT = 2000;
    // settling time after the last result
    localparam int TAIL_CYCLES = 24;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               i_req_type  = REQ_FIND;
    logic [31:0]        i_key       = '0;
    logic               i_out_stall = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               i_cfg_data  = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic [COUNT_W-1:0] o_position;
    logic               o_status;
    logic [COUNT_W-1:0] o_entry_count;
    logic               o_cfg_ready;

    table_scoreboard sb;

    // idling control: quiet_tail switches both sides to full rate for the last stretch
    bit quiet_tail   = 1'b0;
    int send_mode    = 0;
    int stall_left   = 0;
    int stall_mode   = 0;
    int mode_timer   = 0;
    int quiet_cycles = 0;

    sorted_table_insert u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_key         (i_key),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_position    (o_position),
        .o_status      (o_status),
        .o_entry_count (o_entry_count),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // monitor: every handshake is seen at the rising edge, before the rtl updates
    // a result always belongs to an earlier request, so the check goes first
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) sb.set_order(i_cfg_data);
            if (o_out_valid && !i_out_stall) sb.check_result(o_position, o_status, o_entry_count);
            if (i_in_valid && !o_in_stall) sb.note_request(i_req_type, i_key);
        end
    end

    // watchdog: counts cycles in which no transaction completes on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_cfg_valid && o_cfg_ready) || (o_out_valid && !i_out_stall)
                || (i_in_valid && !o_in_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no transaction for %0d cycles, %0d results outstanding",
                     quiet_cycles, sb.waiting());
            $display("sorted_table_insert: mismatch");
            $finish;
        end
    end

    // result-side back-pressure: stall bursts whose length is drawn at random, the stall
    // released between bursts, density re-chosen when the mode timer expires (none, light, heavy)
    always @(negedge i_clk) begin
        if (mode_timer == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_timer = 64;
        end
        mode_timer--;
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (!quiet_tail && !i_out_stall && stall_mode != 0
                     && $urandom_range(0, stall_mode == 1 ? 9 : 2) == 0) begin
            stall_left = $urandom_range(0, 5);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // key mix: repeats of held keys for equal-key ordering, the range extremes,
    // tight clusters around zero, minus one and the sign boundary, and plain random
    function automatic logic [31:0] pick_key(bit nonneg_only);
        logic [31:0] k;
        int unsigned n;
        n = sb.held_keys.size();
        case ($urandom_range(0, 9))
            0, 1, 2: k = (n != 0) ? sb.held_keys[$urandom_range(0, n - 1)] : $urandom;
            3: begin
                case ($urandom_range(0, 5))
                    0:       k = 32'h0000_0000;
                    1:       k = 32'hFFFF_FFFF;
                    2:       k = 32'h7FFF_FFFF;
                    3:       k = 32'h8000_0000;
                    4:       k = 32'h0000_0001;
                    default: k = 32'hFFFF_FFFE;
                endcase
            end
            4, 5: begin
                k = $urandom_range(0, 15);
                if ($urandom_range(0, 1) == 1) k = ~k;
            end
            6:       k = SIGN_BIT + $urandom_range(0, 7) - 4;
            default: k = $urandom;
        endcase
        // while the table is built in unsigned order only non-negative keys go in,
        // so that it stays ascending once the order switches to two's complement
        if (nonneg_only) k[31] = 1'b0;
        return k;
    endfunction

    // one request transaction, with an optional idle gap in front of it;
    // returns at the rising edge where it was accepted
    task automatic send_request(logic req, logic [31:0] k);
        @(negedge i_clk);
        if (!quiet_tail && send_mode != 0
                && $urandom_range(0, send_mode == 1 ? 7 : 2) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_key      <= k;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // sender stops and waits until every predicted result has been checked
    task automatic hold_until_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.waiting() != 0) @(posedge i_clk);
    endtask

    task automatic write_order(logic sgn);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= sgn;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_random(int count, int insert_pct, bit nonneg_only);
        for (int i = 0; i < count; i++) begin
            // sender gap density changes every 32 requests
            if (i % 32 == 0) send_mode = $urandom_range(0, 2);
            send_request(($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_FIND,
                         pick_key(nonneg_only));
        end
    endtask

    initial begin
        sb = new();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // unsigned order, written explicitly even though it is the reset value
        write_order(1'b0);

        // empty table: both extremes land at zero
        send_request(REQ_FIND,   32'h0000_0000);
        send_request(REQ_FIND,   32'hFFFF_FFFF);
        // duplicates go after the entry already held
        send_request(REQ_INSERT, 32'h0000_0010);
        send_request(REQ_INSERT, 32'h0000_0010);
        send_request(REQ_INSERT, 32'h0000_0000);
        send_request(REQ_INSERT, 32'h7FFF_FFFF);
        send_request(REQ_INSERT, 32'h7FFF_FFFE);
        send_request(REQ_FIND,   32'h0000_0000);
        send_request(REQ_FIND,   32'hFFFF_FFFF);
        send_request(REQ_FIND,   32'h8000_0000);
        send_request(REQ_FIND,   32'h0000_0010);
        send_request(REQ_FIND,   32'h0000_000F);
        send_request(REQ_INSERT, 32'h0000_0001);
        send_request(REQ_FIND,   32'h5555_5555);
        send_request(REQ_FIND,   32'hAAAA_AAAA);
        send_request(REQ_INSERT, 32'h5555_5555);

        run_random(400, 40, 1'b1);

        // outstanding results drained before the order register changes
        hold_until_drained();
        write_order(1'b1);

        // two's complement order: negatives now rank below every held key
        send_request(REQ_FIND,   32'h8000_0000);
        send_request(REQ_FIND,   32'hFFFF_FFFF);
        send_request(REQ_INSERT, 32'h8000_0000);
        send_request(REQ_INSERT, 32'hFFFF_FFFF);
        send_request(REQ_INSERT, 32'h0000_0000);
        send_request(REQ_FIND,   32'h7FFF_FFFF);

        // this phase fills the table, then inserts start being refused
        run_random(500, 50, 1'b0);
        hold_until_drained();

        // last stretch at full rate on both sides
        quiet_tail = 1'b1;
        run_random(480, 50, 1'b0);
        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d finds and %0d inserts, %0d of them refused on a full table",
                 sb.finds, sb.inserts, sb.refused);
        $display("%0d results checked in unsigned and signed order, %0d after an equal key",
                 sb.checked, sb.ties);
        if (sb.failures == 0 && sb.waiting() == 0) begin
            $display("sorted_table_insert: match");
        end else begin
            $display("sorted_table_insert: mismatch");
        end
        $finish;
    end

endmodule
